FILE: src/swd_pkg.sv
// Shared types and constants for the stillness window detector.
// No dependencies; used by the squarer and the top level.
package swd_pkg;

	localparam int HISTORY_DEPTH_DEF = 64;

	// item kinds carried on tuser
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_WINDOW   = 3'd0;
	localparam logic [2:0] CFG_HORIZ    = 3'd1;
	localparam logic [2:0] CFG_VERT     = 3'd2;
	localparam logic [2:0] CFG_ATTITUDE = 3'd3;
	localparam logic [2:0] CFG_HEADING  = 3'd4;
	localparam logic [2:0] CFG_SPEED    = 3'd5;

	localparam logic [30:0] WINDOW_RST   = 31'd1000000;
	localparam logic [22:0] HORIZ_RST    = 23'd100;
	localparam logic [22:0] VERT_RST     = 23'd100;
	localparam logic [14:0] ATTITUDE_RST = 15'd182;
	localparam logic [14:0] HEADING_RST  = 15'd182;
	localparam logic [15:0] SPEED_RST    = 16'd100;

	// squarer operand width: covers a 24-bit difference
	localparam int SQ_W = 25;

	typedef struct packed {
		logic [15:0] yaw;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic [23:0] pos_z;
		logic [23:0] pos_y;
		logic [23:0] pos_x;
		logic [31:0] stamp;
	} entry_t;

	// result flags, still in the lowest bit
	typedef struct packed {
		logic overflow_drop;
		logic recently_moving;
		logic yaw_over;
		logic pitch_over;
		logic roll_over;
		logic vertical_over;
		logic horizontal_over;
		logic window_filled;
		logic still;
	} res_t;

endpackage

FILE: src/stillness_window_detector.sv
// Top level of the stillness window detector: sequencer, ring control, registers.
// Depends on swd_pkg, swd_ram (sample ring) and swd_sqr (shared squarer).
//
// Usage
//   Input stream s_*: one transfer per item, tuser = kind (sample, start, stop),
//   tdata = timestamp and pose/velocity fields. Output stream m_*: exactly one
//   transfer of nine status flags per input item, in input order.
//   Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// Timing
//   s_tready is high only while the sequencer is idle. Start, stop and ignored
//   items go from decode straight to emit. An armed sample passes through append,
//   then read and check, repeated for each entry aged out of the window:
//   each pop is one ring read plus one age compare on the single read port,
//   and the seven squares (speed, speed limit, horizontal distance and limit)
//   go one per cycle through the one shared squarer.
// Reset
//   arst_n clears the ring pointers, flags and output valid, and loads the
//   register defaults; ring contents are not cleared.
// Back-pressure
//   The result sits in an output register; a new item is accepted while it
//   waits. The next result holds in the sequencer until m_tready frees the slot.
module stillness_window_detector #(
	parameter int HISTORY_DEPTH = swd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// fields from bit 0: timestamp[31:0], pos_x[55:32], pos_y[79:56],
	// pos_z[103:80], roll_angle[119:104], pitch_angle[135:120],
	// yaw_angle[151:136], vel_x[167:152], vel_y[183:168], vel_z[199:184]
	input  logic [199:0] s_tdata,
	// fields from bit 0: op[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fields from bit 0: still, window_filled, horizontal_over, vertical_over,
	// roll_over, pitch_over, yaw_over, recently_moving, overflow_drop, zeros
	output logic [15:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	localparam int IW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_APPEND = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_SQUARE = 3'd5;
	localparam logic [2:0] ST_EVAL   = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	// squarer steps
	localparam logic [2:0] SQ_VX    = 3'd0;
	localparam logic [2:0] SQ_VY    = 3'd1;
	localparam logic [2:0] SQ_VZ    = 3'd2;
	localparam logic [2:0] SQ_SLIM  = 3'd3;
	localparam logic [2:0] SQ_DX    = 3'd4;
	localparam logic [2:0] SQ_DY    = 3'd5;
	localparam logic [2:0] SQ_HLIM  = 3'd6;
	localparam logic [2:0] SQ_DRAIN = 3'd7;

	logic [2:0] state_q;

	// configuration
	logic [30:0] window_q;
	logic [22:0] hlim_q;
	logic [22:0] vlim_q;
	logic [14:0] alim_q;
	logic [14:0] hdlim_q;
	logic [15:0] slim_q;

	// latched item
	logic [1:0]  op_q;
	logic [31:0] ts_q;
	logic [23:0] px_q, py_q, pz_q;
	logic [15:0] roll_q, pitch_q, yaw_q;
	logic [15:0] vx_q, vy_q, vz_q;

	// ring and detector state
	logic [IW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic          filled_q;
	logic          armed_q;
	logic [31:0]   lft_q;
	logic          ovf_q;

	// squarer bookkeeping
	logic [2:0]  step_q;
	logic [2:0]  sel_s1;
	logic [31:0] spd_q;
	logic [31:0] slim2_q;
	logic [48:0] hacc_q;
	logic [48:0] hlim2_q;

	swd_pkg::res_t res_q;
	swd_pkg::res_t m_data_q;
	logic          m_valid_q;

	// RAM
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	swd_pkg::entry_t ram_wdata;
	logic           ram_re;
	swd_pkg::entry_t ram_rdata;

	logic signed [swd_pkg::SQ_W-1:0]   sq_operand;
	logic        [2*swd_pkg::SQ_W-1:0] sq_out;

	logic          out_free;
	logic          ring_full;
	logic [CW:0]   slot_sum;
	logic [IW-1:0] append_slot;
	logic [IW-1:0] oldest_inc;
	logic [31:0]   age;
	logic          pop;

	logic signed [24:0] dx, dy, dz;
	logic signed [16:0] dr, dp, dw;
	logic [24:0] mag_z;
	logic [16:0] mag_r, mag_p, mag_w;
	logic        fast;
	logic [31:0] lft_new;
	swd_pkg::res_t eval_res;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, m_data_q};
	assign out_free = !m_valid_q || m_tready;

	// ring slot arithmetic, sums stay below twice the depth
	assign ring_full  = (count_q == CW'(HISTORY_DEPTH));
	assign slot_sum   = (CW+1)'(oldest_q) + (CW+1)'(count_q);
	assign append_slot = (slot_sum >= (CW+1)'(HISTORY_DEPTH))
		? IW'(slot_sum - (CW+1)'(HISTORY_DEPTH)) : IW'(slot_sum);
	assign oldest_inc = (oldest_q == IW'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	assign ram_we    = (state_q == ST_APPEND);
	assign ram_waddr = ring_full ? oldest_q : append_slot;
	assign ram_wdata = '{yaw: yaw_q, pitch: pitch_q, roll: roll_q, pos_z: pz_q,
		pos_y: py_q, pos_x: px_q, stamp: ts_q};
	assign ram_re    = (state_q == ST_READ);

	swd_ram #(
		.WIDTH($bits(swd_pkg::entry_t)),
		.DEPTH(HISTORY_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(oldest_q),
		.rdata(ram_rdata)
	);

	// age of the oldest entry against the newest stamp, modulo 2^32
	assign age = ts_q - ram_rdata.stamp;
	assign pop = (count_q > CW'(1)) && (age > {1'b0, window_q});

	// newest minus oldest; oldest comes from the RAM read register
	assign dx = $signed({px_q[23], px_q}) - $signed({ram_rdata.pos_x[23], ram_rdata.pos_x});
	assign dy = $signed({py_q[23], py_q}) - $signed({ram_rdata.pos_y[23], ram_rdata.pos_y});
	assign dz = $signed({pz_q[23], pz_q}) - $signed({ram_rdata.pos_z[23], ram_rdata.pos_z});
	assign dr = $signed({roll_q[15], roll_q}) - $signed({ram_rdata.roll[15], ram_rdata.roll});
	assign dp = $signed({pitch_q[15], pitch_q})
		- $signed({ram_rdata.pitch[15], ram_rdata.pitch});
	assign dw = $signed({yaw_q[15], yaw_q}) - $signed({ram_rdata.yaw[15], ram_rdata.yaw});

	assign mag_z = dz[24] ? $unsigned(-dz) : $unsigned(dz);
	assign mag_r = dr[16] ? $unsigned(-dr) : $unsigned(dr);
	assign mag_p = dp[16] ? $unsigned(-dp) : $unsigned(dp);
	assign mag_w = dw[16] ? $unsigned(-dw) : $unsigned(dw);

	always_comb begin
		case (step_q)
			SQ_VX:   sq_operand = $signed({{9{vx_q[15]}}, vx_q});
			SQ_VY:   sq_operand = $signed({{9{vy_q[15]}}, vy_q});
			SQ_VZ:   sq_operand = $signed({{9{vz_q[15]}}, vz_q});
			SQ_SLIM: sq_operand = $signed({9'b0, slim_q});
			SQ_DX:   sq_operand = dx;
			SQ_DY:   sq_operand = dy;
			SQ_HLIM: sq_operand = $signed({2'b0, hlim_q});
			default: sq_operand = '0;
		endcase
	end

	swd_sqr u_sqr (
		.clk      (clk),
		.operand  (sq_operand),
		.square_s1(sq_out)
	);

	// final checks
	assign fast    = spd_q > slim2_q;
	assign lft_new = fast ? ts_q : lft_q;

	always_comb begin
		eval_res = '0;
		eval_res.overflow_drop = ovf_q;
		if (filled_q) begin
			eval_res.window_filled   = 1'b1;
			eval_res.horizontal_over = hacc_q > hlim2_q;
			eval_res.vertical_over   = mag_z > {2'b0, vlim_q};
			eval_res.roll_over       = mag_r > {2'b0, alim_q};
			eval_res.pitch_over      = mag_p > {2'b0, alim_q};
			eval_res.yaw_over        = mag_w > {2'b0, hdlim_q};
			eval_res.recently_moving = (ts_q - lft_new) < {1'b0, window_q};
			eval_res.still = !(eval_res.horizontal_over || eval_res.vertical_over
				|| eval_res.roll_over || eval_res.pitch_over || eval_res.yaw_over
				|| eval_res.recently_moving);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swd_pkg::WINDOW_RST;
			hlim_q   <= swd_pkg::HORIZ_RST;
			vlim_q   <= swd_pkg::VERT_RST;
			alim_q   <= swd_pkg::ATTITUDE_RST;
			hdlim_q  <= swd_pkg::HEADING_RST;
			slim_q   <= swd_pkg::SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				swd_pkg::CFG_WINDOW:   window_q <= cfg_data;
				swd_pkg::CFG_HORIZ:    hlim_q   <= cfg_data[22:0];
				swd_pkg::CFG_VERT:     vlim_q   <= cfg_data[22:0];
				swd_pkg::CFG_ATTITUDE: alim_q   <= cfg_data[14:0];
				swd_pkg::CFG_HEADING:  hdlim_q  <= cfg_data[14:0];
				swd_pkg::CFG_SPEED:    slim_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// item capture, unpacked from tdata
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tuser;
			ts_q    <= s_tdata[31:0];
			px_q    <= s_tdata[55:32];
			py_q    <= s_tdata[79:56];
			pz_q    <= s_tdata[103:80];
			roll_q  <= s_tdata[119:104];
			pitch_q <= s_tdata[135:120];
			yaw_q   <= s_tdata[151:136];
			vx_q    <= s_tdata[167:152];
			vy_q    <= s_tdata[183:168];
			vz_q    <= s_tdata[199:184];
		end
	end

	// squarer accumulation: sel_s1 tags the product now on sq_out
	always_ff @(posedge clk) begin
		sel_s1 <= step_q;
		if (state_q == ST_SQUARE && step_q != SQ_VX) begin
			case (sel_s1)
				SQ_VX:   spd_q   <= sq_out[31:0];
				SQ_VY:   spd_q   <= spd_q + sq_out[31:0];
				SQ_VZ:   spd_q   <= spd_q + sq_out[31:0];
				SQ_SLIM: slim2_q <= sq_out[31:0];
				SQ_DX:   hacc_q  <= {1'b0, sq_out[47:0]};
				SQ_DY:   hacc_q  <= hacc_q + {1'b0, sq_out[47:0]};
				SQ_HLIM: hlim2_q <= {1'b0, sq_out[47:0]};
				default: begin
				end
			endcase
		end
	end

	// sequencer and ring control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
			filled_q <= 1'b0;
			armed_q  <= 1'b0;
			lft_q    <= '0;
			ovf_q    <= 1'b0;
			step_q   <= SQ_VX;
			res_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_q   <= '0;
					state_q <= ST_EMIT;
					case (op_q)
						swd_pkg::OP_START: begin
							oldest_q <= '0;
							count_q  <= '0;
							filled_q <= 1'b0;
							armed_q  <= 1'b1;
							lft_q    <= ts_q;
						end
						swd_pkg::OP_STOP: begin
							armed_q <= 1'b0;
						end
						swd_pkg::OP_SAMPLE: begin
							if (armed_q) begin
								state_q <= ST_APPEND;
							end
						end
						default: begin
						end
					endcase
				end
				ST_APPEND: begin
					// full ring: new entry overwrites the oldest slot
					if (ring_full) begin
						oldest_q <= oldest_inc;
						ovf_q    <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						ovf_q   <= 1'b0;
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (pop) begin
						oldest_q <= oldest_inc;
						count_q  <= count_q - 1'b1;
						filled_q <= 1'b1;
						state_q  <= ST_READ;
					end else begin
						step_q  <= SQ_VX;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					step_q <= step_q + 1'b1;
					if (step_q == SQ_DRAIN) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					lft_q <= lft_new;
					res_q <= eval_res;
					if (eval_res.still) begin
						armed_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_data_q <= res_q;
		end
	end

endmodule

FILE: src/swd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/swd_sqr.sv
// Shared signed squarer, one registered product per cycle.
// Depends on swd_pkg for the operand width.
module swd_sqr (
	input  logic                              clk,
	input  logic signed [swd_pkg::SQ_W-1:0]   operand,
	output logic        [2*swd_pkg::SQ_W-1:0] square_s1
);

	logic signed [2*swd_pkg::SQ_W-1:0] prod;

	assign prod = operand * operand;

	always_ff @(posedge clk) begin
		square_s1 <= $unsigned(prod);
	end

endmodule
